// ===== rtl/bgc_pkg.sv =====
// Shared constants, codes and types for the breakpoint gain curve table.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package bgc_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int FREQ_BITS   = 20;
  localparam int GAIN_BITS   = 16;
  localparam int ADDR_BITS   = $clog2(MAX_POINTS);
  localparam int PTR_BITS    = $clog2(MAX_POINTS + 1);
  localparam int CMD_BITS    = 3;
  localparam int IDX_BITS    = 6;
  localparam int CNT_BITS    = 7;
  localparam int STATUS_BITS = 2;

  // Divider sizes: the doubled area fits in ACC_BITS, the divisor is a width or twice a width.
  localparam int ACC_BITS  = FREQ_BITS + GAIN_BITS + 2;
  localparam int PROD_BITS = FREQ_BITS + GAIN_BITS + 1;
  localparam int DVS_BITS  = FREQ_BITS + 1;
  localparam int REM_BITS  = FREQ_BITS + 2;
  localparam int DCNT_BITS = $clog2(ACC_BITS + 1);

  localparam logic [GAIN_BITS-1:0] GAIN_ONE     = GAIN_BITS'(4096);
  localparam logic [FREQ_BITS-1:0] SEED_LO_FREQ = FREQ_BITS'(320);
  localparam logic [FREQ_BITS-1:0] SEED_HI_FREQ = FREQ_BITS'(320000);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SET, CMD_REM_IDX, CMD_REM_FREQ, CMD_CLEAR,
    CMD_POINT, CMD_BAND, CMD_MAX, CMD_MEAN
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK, ST_NOT_FOUND, ST_FULL, ST_INDEX
  } status_t;

  typedef enum logic [2:0] {
    I_HOLD, I_ZERO, I_INC, I_DEC, I_COUNT, I_LAST, I_IDX
  } idx_op_t;

  typedef enum logic [1:0] { RD_I, RD_IM1, RD_IP1 } rd_sel_t;

  typedef enum logic [1:0] { WR_SHIFT, WR_NEW, WR_SEED_LO, WR_SEED_HI } wr_sel_t;

  typedef enum logic [2:0] { C_HOLD, C_INC, C_DEC, C_ZERO, C_TWO } cnt_op_t;

  typedef enum logic [2:0] { Q_HOLD, Q_FA, Q_LO, Q_HI, Q_ZERO } qf_op_t;

  typedef enum logic [1:0] { B_HOLD, B_EDGES, B_LO_RD, B_HI_RD } band_op_t;

  typedef enum logic [2:0] { G_HOLD, G_ONE, G_RD, G_PREV, G_QUOT } gp_op_t;

  typedef enum logic [2:0] { R_HOLD, R_ZERO, R_GP, R_QUOT, R_MAX, R_ONE } res_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE, S_DONE,
    S_SET_RD, S_SET_CHK, S_SET_END, S_INS_CHK, S_INS_RD, S_INS_WR,
    S_REM_CHK, S_REM_RD, S_REM_WR, S_RF_RD, S_RF_CHK,
    S_CLR, S_CLR2,
    S_GA_START, S_GA_RD, S_GA_CHK, S_GA_MUL, S_GA_DIVS, S_GA_DIV, S_GP_RES,
    S_BD_GLO, S_BD_GHI, S_BD_SC0, S_BD_RD, S_BD_CHK, S_BD_ADD,
    S_BD_LAST, S_BD_LADD, S_BD_DIVS, S_BD_DIV,
    S_MX_RD, S_MX_CHK, S_TM_RD0, S_TM_CHK0, S_TM_RD1, S_TM_CHK1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    idx_op_t  i_op;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    logic     pos_load;
    qf_op_t   qf_op;
    band_op_t band_op;
    logic     gx_init;
    logic     ghi_load;
    logic     acc_clr;
    logic     piece_mul;
    logic     last_mul;
    logic     acc_add;
    logic     prev_load;
    logic     seg_load;
    logic     seg_mul;
    logic     div_seg;
    logic     div_band;
    gp_op_t   gp_op;
    res_op_t  res_op;
    logic     st_load;
    status_t  st_val;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic i_eq_cnt;
    logic i_zero;
    logic i_eq_pos;
    logic i1_ge_cnt;
    logic idx_ge_cnt;
    logic fa_eq_fb;
    logic g_is_one;
    logic rd_eq_fa;
    logic rd_gt_fa;
    logic rd_gt_qf;
    logic rd_in_band;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/bgc_ctrl.sv =====
// Controller state machine of the breakpoint gain curve table.
// Sequences table scans, shifts, queries and divisions; depends on bgc_pkg.
module bgc_ctrl import bgc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  c
);

  state_t state, state_next;
  state_t ret, ret_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // State, return point of the gain lookup, and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (c.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_SET:      state_next = S_SET_RD;
          CMD_REM_IDX:  state_next = stat.idx_ge_cnt ? S_DONE : S_REM_CHK;
          CMD_REM_FREQ: state_next = S_RF_RD;
          CMD_CLEAR:    state_next = S_CLR;
          CMD_POINT: begin
            ret_next   = S_GP_RES;
            state_next = S_GA_START;
          end
          CMD_BAND: begin
            if (stat.cnt_lt2 || stat.fa_eq_fb) begin
              ret_next   = S_GP_RES;
              state_next = S_GA_START;
            end else begin
              state_next = S_BD_GLO;
            end
          end
          CMD_MAX: state_next = stat.cnt_zero ? S_DONE : S_MX_RD;
          default: begin
            if (stat.cnt_lt2) begin
              ret_next   = S_GP_RES;
              state_next = S_GA_START;
            end else begin
              state_next = S_TM_RD0;
            end
          end
        endcase
      end
      S_DONE:    if (out_free) state_next = S_IDLE;
      S_SET_RD:  state_next = stat.i_eq_cnt ? S_SET_END : S_SET_CHK;
      S_SET_CHK: begin
        if (stat.rd_eq_fa) state_next = S_DONE;
        else if (stat.rd_gt_fa) state_next = S_SET_END;
        else state_next = S_SET_RD;
      end
      S_SET_END: state_next = stat.cnt_full ? S_DONE : S_INS_CHK;
      S_INS_CHK: state_next = stat.i_eq_pos ? S_DONE : S_INS_RD;
      S_INS_RD:  state_next = S_INS_WR;
      S_INS_WR:  state_next = S_INS_CHK;
      S_REM_CHK: state_next = stat.i1_ge_cnt ? S_DONE : S_REM_RD;
      S_REM_RD:  state_next = S_REM_WR;
      S_REM_WR:  state_next = S_REM_CHK;
      S_RF_RD:   state_next = stat.i_eq_cnt ? S_DONE : S_RF_CHK;
      S_RF_CHK:  state_next = stat.rd_eq_fa ? S_REM_CHK : S_RF_RD;
      S_CLR:     state_next = stat.g_is_one ? S_DONE : S_CLR2;
      S_CLR2:    state_next = S_DONE;
      S_GA_START: state_next = stat.cnt_zero ? ret : S_GA_RD;
      S_GA_RD:   state_next = stat.i_eq_cnt ? ret : S_GA_CHK;
      S_GA_CHK: begin
        if (stat.rd_gt_qf) state_next = stat.i_zero ? ret : S_GA_MUL;
        else state_next = S_GA_RD;
      end
      S_GA_MUL:  state_next = S_GA_DIVS;
      S_GA_DIVS: state_next = S_GA_DIV;
      S_GA_DIV:  if (stat.div_done) state_next = ret;
      S_GP_RES:  state_next = S_DONE;
      S_BD_GLO: begin
        ret_next   = S_BD_GHI;
        state_next = S_GA_START;
      end
      S_BD_GHI: begin
        ret_next   = S_BD_SC0;
        state_next = S_GA_START;
      end
      S_BD_SC0:  state_next = S_BD_RD;
      S_BD_RD:   state_next = stat.i_eq_cnt ? S_BD_LAST : S_BD_CHK;
      S_BD_CHK:  state_next = stat.rd_in_band ? S_BD_ADD : S_BD_RD;
      S_BD_ADD:  state_next = S_BD_RD;
      S_BD_LAST: state_next = S_BD_LADD;
      S_BD_LADD: state_next = S_BD_DIVS;
      S_BD_DIVS: state_next = S_BD_DIV;
      S_BD_DIV:  if (stat.div_done) state_next = S_DONE;
      S_MX_RD:   state_next = stat.i_eq_cnt ? S_DONE : S_MX_CHK;
      S_MX_CHK:  state_next = S_MX_RD;
      S_TM_RD0:  state_next = S_TM_CHK0;
      S_TM_CHK0: state_next = S_TM_RD1;
      S_TM_RD1:  state_next = S_TM_CHK1;
      S_TM_CHK1: state_next = S_BD_GLO;
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    c = '0;
    case (state)
      S_IDLE: c.load_in = in_valid;
      S_DECODE: begin
        c.res_op  = R_ZERO;
        c.st_load = 1'b1;
        c.st_val  = ST_OK;
        c.i_op    = I_ZERO;
        case (stat.cmd)
          CMD_REM_IDX: begin
            if (stat.idx_ge_cnt) c.st_val = ST_INDEX;
            else c.i_op = I_IDX;
          end
          CMD_POINT: c.qf_op = Q_FA;
          CMD_BAND: begin
            if (stat.cnt_lt2 || stat.fa_eq_fb) c.qf_op = Q_FA;
            else c.band_op = B_EDGES;
          end
          CMD_MAX: if (stat.cnt_zero) c.res_op = R_ONE;
          CMD_MEAN: if (stat.cnt_lt2) c.qf_op = Q_ZERO;
          default: ;
        endcase
      end
      S_DONE: c.out_load = out_free;
      S_SET_CHK: begin
        if (stat.rd_eq_fa) begin
          c.wr_en  = 1'b1;
          c.wr_sel = WR_NEW;
        end else if (!stat.rd_gt_fa) begin
          c.i_op = I_INC;
        end
      end
      S_SET_END: begin
        if (stat.cnt_full) begin
          c.st_load = 1'b1;
          c.st_val  = ST_FULL;
        end else begin
          c.pos_load = 1'b1;
          c.i_op     = I_COUNT;
        end
      end
      S_INS_CHK: begin
        if (stat.i_eq_pos) begin
          c.wr_en  = 1'b1;
          c.wr_sel = WR_NEW;
          c.cnt_op = C_INC;
        end
      end
      S_INS_RD: c.rd_sel = RD_IM1;
      S_INS_WR: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WR_SHIFT;
        c.i_op   = I_DEC;
      end
      S_REM_CHK: if (stat.i1_ge_cnt) c.cnt_op = C_DEC;
      S_REM_RD:  c.rd_sel = RD_IP1;
      S_REM_WR: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WR_SHIFT;
        c.i_op   = I_INC;
      end
      S_RF_RD: begin
        if (stat.i_eq_cnt) begin
          c.st_load = 1'b1;
          c.st_val  = ST_NOT_FOUND;
        end
      end
      S_RF_CHK: if (!stat.rd_eq_fa) c.i_op = I_INC;
      S_CLR: begin
        c.cnt_op = C_ZERO;
        if (!stat.g_is_one) begin
          c.wr_en  = 1'b1;
          c.wr_sel = WR_SEED_LO;
          c.i_op   = I_INC;
        end
      end
      S_CLR2: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WR_SEED_HI;
        c.cnt_op = C_TWO;
      end
      S_GA_START: begin
        if (stat.cnt_zero) c.gp_op = G_ONE;
        c.i_op = I_ZERO;
      end
      S_GA_RD: if (stat.i_eq_cnt) c.gp_op = G_PREV;
      S_GA_CHK: begin
        if (stat.rd_gt_qf) begin
          if (stat.i_zero) c.gp_op = G_RD;
          else c.seg_load = 1'b1;
        end else begin
          c.prev_load = 1'b1;
          c.i_op      = I_INC;
        end
      end
      S_GA_MUL:  c.seg_mul = 1'b1;
      S_GA_DIVS: c.div_seg = 1'b1;
      S_GA_DIV:  if (stat.div_done) c.gp_op = G_QUOT;
      S_GP_RES:  c.res_op = R_GP;
      S_BD_GLO:  c.qf_op = Q_LO;
      S_BD_GHI: begin
        c.gx_init = 1'b1;
        c.qf_op   = Q_HI;
      end
      S_BD_SC0: begin
        c.ghi_load = 1'b1;
        c.acc_clr  = 1'b1;
        c.i_op     = I_ZERO;
      end
      S_BD_CHK: begin
        c.i_op      = I_INC;
        c.piece_mul = stat.rd_in_band;
      end
      S_BD_ADD:  c.acc_add = 1'b1;
      S_BD_LAST: c.last_mul = 1'b1;
      S_BD_LADD: c.acc_add = 1'b1;
      S_BD_DIVS: c.div_band = 1'b1;
      S_BD_DIV:  if (stat.div_done) c.res_op = R_QUOT;
      S_MX_CHK: begin
        c.res_op = R_MAX;
        c.i_op   = I_INC;
      end
      S_TM_CHK0: begin
        c.band_op = B_LO_RD;
        c.i_op    = I_LAST;
      end
      S_TM_CHK1: c.band_op = B_HI_RD;
      default: ;
    endcase
  end

endmodule

// ===== rtl/bgc_dp.sv =====
// Datapath of the breakpoint gain curve table: breakpoint memory, scan index,
// interpolation multipliers, area accumulator, shared divider, result register.
// Depends on bgc_pkg.
module bgc_dp import bgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              c,
  output dp_stat_t             stat,
  input  logic [CMD_BITS-1:0]  cmd,
  input  logic [FREQ_BITS-1:0] freq_a,
  input  logic [FREQ_BITS-1:0] freq_b,
  input  logic [GAIN_BITS-1:0] gain_in,
  input  logic [IDX_BITS-1:0]  entry_index,
  output logic [GAIN_BITS-1:0] gain_out,
  output logic [1:0]           status,
  output logic [CNT_BITS-1:0]  entry_count
);

  logic [FREQ_BITS-1:0] mem_f [0:MAX_POINTS-1];
  logic [GAIN_BITS-1:0] mem_g [0:MAX_POINTS-1];
  logic [FREQ_BITS-1:0] rdf;
  logic [GAIN_BITS-1:0] rdg;
  logic [ADDR_BITS-1:0] raddr, waddr;
  logic [FREQ_BITS-1:0] wdf;
  logic [GAIN_BITS-1:0] wdg;

  cmd_t                 cmd_r;
  logic [FREQ_BITS-1:0] fa, fb;
  logic [GAIN_BITS-1:0] gin;
  logic [IDX_BITS-1:0]  idx;
  logic [PTR_BITS-1:0]  count, i, p, i_m1, i_p1;

  logic [FREQ_BITS-1:0] qf, lo, hi, x, prevf, segf;
  logic [GAIN_BITS-1:0] gx, ghi, prevg, segg, gp, res;
  status_t              st;
  logic [PROD_BITS-2:0] p0, p1;
  logic [PROD_BITS-1:0] prod;
  logic [ACC_BITS-1:0]  acc;

  logic [ACC_BITS-1:0]  dd, qt;
  logic [DVS_BITS-1:0]  dv;
  logic [REM_BITS-1:0]  rm, rm_sh;
  logic [DCNT_BITS-1:0] dcnt;

  logic [FREQ_BITS-1:0] pw;
  logic [GAIN_BITS:0]   ps;

  assign i_m1 = i - PTR_BITS'(1);
  assign i_p1 = i + PTR_BITS'(1);

  // Read and write addresses and write data.
  always_comb begin
    case (c.rd_sel)
      RD_IM1:  raddr = i_m1[ADDR_BITS-1:0];
      RD_IP1:  raddr = i_p1[ADDR_BITS-1:0];
      default: raddr = i[ADDR_BITS-1:0];
    endcase
    waddr = i[ADDR_BITS-1:0];
    case (c.wr_sel)
      WR_SHIFT:   begin wdf = rdf;          wdg = rdg; end
      WR_SEED_LO: begin wdf = SEED_LO_FREQ; wdg = gin; end
      WR_SEED_HI: begin wdf = SEED_HI_FREQ; wdg = gin; end
      default:    begin wdf = fa;           wdg = gin; end
    endcase
  end

  // Breakpoint memory with registered read.
  always_ff @(posedge clk) begin
    if (c.wr_en) begin
      mem_f[waddr] <= wdf;
      mem_g[waddr] <= wdg;
    end
    rdf <= mem_f[raddr];
    rdg <= mem_g[raddr];
  end

  // Breakpoint count and scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (c.cnt_op)
        C_INC:   count <= count + PTR_BITS'(1);
        C_DEC:   count <= count - PTR_BITS'(1);
        C_ZERO:  count <= '0;
        C_TWO:   count <= PTR_BITS'(2);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (c.i_op)
      I_ZERO:  i <= '0;
      I_INC:   i <= i_p1;
      I_DEC:   i <= i_m1;
      I_COUNT: i <= count;
      I_LAST:  i <= count - PTR_BITS'(1);
      I_IDX:   i <= PTR_BITS'(idx);
      default: ;
    endcase
    if (c.pos_load) p <= i;
  end

  // Transfer fields and query operands.
  always_ff @(posedge clk) begin
    if (c.load_in) begin
      cmd_r <= cmd_t'(cmd);
      fa    <= freq_a;
      fb    <= freq_b;
      gin   <= gain_in;
      idx   <= entry_index;
    end
    case (c.qf_op)
      Q_FA:    qf <= fa;
      Q_LO:    qf <= lo;
      Q_HI:    qf <= hi;
      Q_ZERO:  qf <= '0;
      default: ;
    endcase
    case (c.band_op)
      B_EDGES: begin
        lo <= (fa < fb) ? fa : fb;
        hi <= (fa < fb) ? fb : fa;
      end
      B_LO_RD: lo <= rdf;
      B_HI_RD: hi <= rdf;
      default: ;
    endcase
  end

  // Segment interpolation products.
  always_ff @(posedge clk) begin
    if (c.prev_load) begin
      prevf <= rdf;
      prevg <= rdg;
    end
    if (c.seg_load) begin
      segf <= rdf;
      segg <= rdg;
    end
    if (c.seg_mul) begin
      p0 <= prevg * (segf - qf);
      p1 <= segg * (qf - prevf);
    end
  end

  // Trapezoid pieces: width times the sum of the two end gains.
  always_comb begin
    if (c.last_mul) begin
      pw = hi - x;
      ps = {1'b0, gx} + {1'b0, ghi};
    end else begin
      pw = rdf - x;
      ps = {1'b0, gx} + {1'b0, rdg};
    end
  end

  always_ff @(posedge clk) begin
    if (c.gx_init) begin
      gx <= gp;
      x  <= lo;
    end else if (c.piece_mul) begin
      gx <= rdg;
      x  <= rdf;
    end
    if (c.ghi_load) ghi <= gp;
    if (c.piece_mul || c.last_mul) prod <= pw * ps;
    if (c.acc_clr) acc <= '0;
    else if (c.acc_add) acc <= acc + ACC_BITS'(prod);
  end

  // Restoring divider, one quotient bit per cycle.
  assign rm_sh = {rm[REM_BITS-2:0], dd[ACC_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (c.div_seg || c.div_band) begin
      dcnt <= DCNT_BITS'(ACC_BITS);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - DCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (c.div_seg) begin
      dd <= ACC_BITS'({1'b0, p0} + {1'b0, p1});
      dv <= DVS_BITS'(segf - prevf);
      rm <= '0;
      qt <= '0;
    end else if (c.div_band) begin
      dd <= acc;
      dv <= {hi - lo, 1'b0};
      rm <= '0;
      qt <= '0;
    end else if (dcnt != '0) begin
      dd <= {dd[ACC_BITS-2:0], 1'b0};
      if (rm_sh >= REM_BITS'(dv)) begin
        rm <= rm_sh - REM_BITS'(dv);
        qt <= {qt[ACC_BITS-2:0], 1'b1};
      end else begin
        rm <= rm_sh;
        qt <= {qt[ACC_BITS-2:0], 1'b0};
      end
    end
  end

  // Point gain, command result and status.
  always_ff @(posedge clk) begin
    case (c.gp_op)
      G_ONE:   gp <= GAIN_ONE;
      G_RD:    gp <= rdg;
      G_PREV:  gp <= prevg;
      G_QUOT:  gp <= qt[GAIN_BITS-1:0];
      default: ;
    endcase
    case (c.res_op)
      R_ZERO:  res <= '0;
      R_GP:    res <= gp;
      R_QUOT:  res <= qt[GAIN_BITS-1:0];
      R_MAX:   if (rdg > res) res <= rdg;
      R_ONE:   res <= GAIN_ONE;
      default: ;
    endcase
    if (c.st_load) st <= c.st_val;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (c.out_load) begin
      gain_out    <= res;
      status      <= st;
      entry_count <= CNT_BITS'(count);
    end
  end

  // Status flags for the controller.
  always_comb begin
    stat.cmd        = cmd_r;
    stat.cnt_zero   = (count == '0);
    stat.cnt_lt2    = (count < PTR_BITS'(2));
    stat.cnt_full   = (count >= PTR_BITS'(MAX_POINTS));
    stat.i_eq_cnt   = (i == count);
    stat.i_zero     = (i == '0);
    stat.i_eq_pos   = (i == p);
    stat.i1_ge_cnt  = (i_p1 >= count);
    stat.idx_ge_cnt = (PTR_BITS'(idx) >= count);
    stat.fa_eq_fb   = (fa == fb);
    stat.g_is_one   = (gin == GAIN_ONE);
    stat.rd_eq_fa   = (rdf == fa);
    stat.rd_gt_fa   = (rdf > fa);
    stat.rd_gt_qf   = (rdf > qf);
    stat.rd_in_band = (rdf > lo) && (rdf < hi);
    stat.div_done   = (dcnt == '0);
  end

endmodule

// ===== rtl/breakpoint_gain_curve_table.sv =====
// Breakpoint gain curve table. One command at a time; a scan reads and checks one entry at a time
// from the breakpoint memory (one read and one write port), a shift moves one entry per check, read and write.
// The result register lets the next command in while a result waits to be taken.
// Reset empties the table (count zero) and drops out_valid; no clearing pass.
module breakpoint_gain_curve_table import bgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_BITS-1:0]  cmd,
  input  logic [FREQ_BITS-1:0] freq_a,
  input  logic [FREQ_BITS-1:0] freq_b,
  input  logic [GAIN_BITS-1:0] gain_in,
  input  logic [IDX_BITS-1:0]  entry_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [GAIN_BITS-1:0] gain_out,
  output logic [1:0]           status,
  output logic [CNT_BITS-1:0]  entry_count
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  bgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dstat),
    .c         (dcmd)
  );

  bgc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .c           (dcmd),
    .stat        (dstat),
    .cmd         (cmd),
    .freq_a      (freq_a),
    .freq_b      (freq_b),
    .gain_in     (gain_in),
    .entry_index (entry_index),
    .gain_out    (gain_out),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

// ===== rtl/bgc_checker.sv =====
// Port-level checker for the breakpoint gain curve table, bound to the top level.
// Depends on bgc_pkg.
module bgc_props import bgc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [GAIN_BITS-1:0] gain_out,
  input logic [1:0]           status,
  input logic [CNT_BITS-1:0]  entry_count
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gain_out) && $stable(status))
    else $error("stalled result changed");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // The table never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CNT_BITS'(MAX_POINTS))
    else $error("entry count beyond capacity");

  // Errors come only from table-changing commands, which report zero gain.
  a_err_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> gain_out == '0)
    else $error("error status with nonzero gain");

  // A full-table refusal reports a full table.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CNT_BITS'(MAX_POINTS))
    else $error("table full reported below capacity");

endmodule

bind breakpoint_gain_curve_table bgc_props u_bgc_props (.*);
